FILE: sv/dpad_pkg.sv
// Shared types, codes and helper functions for the hat-switch to button event block.
// Used by every RTL module of the block and by its port checker; depends on nothing.
`default_nettype none

package dpad_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] HAT_UP    = 4'd1;
    localparam logic [3:0] HAT_RIGHT = 4'd2;
    localparam logic [3:0] HAT_DOWN  = 4'd4;
    localparam logic [3:0] HAT_LEFT  = 4'd8;
    localparam logic [3:0] HAT_RIGHT_UP   = 4'd3;
    localparam logic [3:0] HAT_RIGHT_DOWN = 4'd6;
    localparam logic [3:0] HAT_LEFT_UP    = 4'd9;
    localparam logic [3:0] HAT_LEFT_DOWN  = 4'd12;

    typedef enum logic [1:0] {
        KIND_ACTIVE   = 2'd0,
        KIND_CENTERED = 2'd1,
        KIND_RELEASE  = 2'd2,
        KIND_PRESS    = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        MODE_STANDARD = 2'd0,
        MODE_EIGHT    = 2'd1,
        MODE_CARDINAL = 2'd2,
        MODE_DIAGONAL = 2'd3
    } pad_mode_t;

    // One classified direction change: a notice, then releases, then presses.
    typedef struct packed {
        logic       flag;
        logic       active;
        logic [3:0] dir;
        logic       rel_one;
        logic [3:0] rel_code;
        logic [3:0] rel_bits;
        logic       prs_one;
        logic [3:0] prs_code;
        logic [3:0] prs_bits;
    } cmd_t;

    function automatic logic is_diagonal(input logic [3:0] c);
        return c inside {HAT_RIGHT_UP, HAT_RIGHT_DOWN, HAT_LEFT_UP, HAT_LEFT_DOWN};
    endfunction

    function automatic logic is_cardinal(input logic [3:0] c);
        return c inside {HAT_UP, HAT_RIGHT, HAT_DOWN, HAT_LEFT};
    endfunction

    // Picks the first set bit in the order up, down, left, right.
    function automatic logic [3:0] first_bit(input logic [3:0] mask);
        logic [3:0] b;
        b = 4'd0;
        if ((mask & HAT_UP) != 4'd0) begin
            b = HAT_UP;
        end else if ((mask & HAT_DOWN) != 4'd0) begin
            b = HAT_DOWN;
        end else if ((mask & HAT_LEFT) != 4'd0) begin
            b = HAT_LEFT;
        end else if ((mask & HAT_RIGHT) != 4'd0) begin
            b = HAT_RIGHT;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dpad_front.sv
// Front end: holds the mode register and the direction state, accepts input words
// and turns each change of direction into one command. Depends on dpad_pkg.
`default_nettype none

module dpad_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [3:0]      s_direction,
    input  wire logic            s_ignore_sets,
    input  wire logic            q_full,
    output logic                 push,
    output dpad_pkg::cmd_t       cmd
);
    import dpad_pkg::*;

    pad_mode_t  pad_mode_reg;
    logic [3:0] prev_dir_reg;
    logic [3:0] held_diag_reg;
    logic [3:0] held_diag_next;
    logic       accept;
    logic       changed;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign changed   = (s_direction != prev_dir_reg);
    assign push      = accept && changed;

    always_comb begin
        cmd            = '0;
        held_diag_next = held_diag_reg;
        cmd.flag       = s_ignore_sets;
        cmd.active     = (s_direction != 4'd0);
        cmd.dir        = s_direction;
        if (changed) begin
            held_diag_next = 4'd0;
            if (held_diag_reg != 4'd0) begin
                cmd.rel_one  = 1'b1;
                cmd.rel_code = held_diag_reg;
            end else if (pad_mode_reg == MODE_STANDARD) begin
                cmd.rel_bits = prev_dir_reg & ~s_direction;
            end else if (is_cardinal(prev_dir_reg) || is_diagonal(prev_dir_reg)) begin
                cmd.rel_one  = 1'b1;
                cmd.rel_code = prev_dir_reg;
            end
            case (pad_mode_reg)
                MODE_STANDARD: begin
                    cmd.prs_bits = s_direction & ~prev_dir_reg;
                end
                MODE_EIGHT: begin
                    if (is_diagonal(s_direction)) begin
                        cmd.prs_one    = 1'b1;
                        cmd.prs_code   = s_direction;
                        held_diag_next = s_direction;
                    end else begin
                        cmd.prs_bits = s_direction & ~prev_dir_reg;
                    end
                end
                MODE_CARDINAL: begin
                    if (is_cardinal(s_direction)) begin
                        cmd.prs_one  = 1'b1;
                        cmd.prs_code = s_direction;
                    end
                end
                MODE_DIAGONAL: begin
                    if (is_diagonal(s_direction)) begin
                        cmd.prs_one    = 1'b1;
                        cmd.prs_code   = s_direction;
                        held_diag_next = s_direction;
                    end
                end
                default: begin
                    cmd.prs_bits = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_mode_reg  <= MODE_STANDARD;
            prev_dir_reg  <= 4'd0;
            held_diag_reg <= 4'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pad_mode_reg <= pad_mode_t'(cfg_data);
            end
            if (accept) begin
                prev_dir_reg  <= s_direction;
                held_diag_reg <= held_diag_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dpad_queue.sv
// Short command queue between the front end and the event sequencer.
// Depends on dpad_pkg for the command type.
`default_nettype none

module dpad_queue #(
    parameter int DEPTH = dpad_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  dpad_pkg::cmd_t   push_data,
    input  wire logic        pop,
    output logic             full,
    output logic             empty,
    output dpad_pkg::cmd_t   pop_data
);
    import dpad_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dpad_back.sv
// Event sequencer: takes commands from the queue and sends their events one word
// per cycle while not stalled, on a registered result port. Depends on dpad_pkg.
`default_nettype none

module dpad_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_empty,
    input  dpad_pkg::cmd_t   q_data,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [3:0]       m_button_code,
    output logic             m_ignore_sets_out,
    output logic             m_last
);
    import dpad_pkg::*;

    cmd_t        work_reg;
    cmd_t        work_next;
    logic        notice_reg;
    logic        notice_next;
    logic        m_valid_reg;
    event_kind_t kind_reg;
    logic [3:0]  code_reg;
    logic        flag_reg;
    logic        last_reg;

    event_kind_t sel_kind;
    logic [3:0]  sel_code;
    logic [3:0]  bit_sel;
    logic        pending;
    logic        can_out;
    logic        emit;
    logic        sel_last;

    assign pending = notice_reg || work_reg.rel_one || (work_reg.rel_bits != 4'd0)
                     || work_reg.prs_one || (work_reg.prs_bits != 4'd0);
    assign can_out = !m_valid_reg || m_ready;
    assign emit    = pending && can_out;

    always_comb begin
        work_next   = work_reg;
        notice_next = notice_reg;
        sel_kind    = KIND_PRESS;
        sel_code    = 4'd0;
        bit_sel     = 4'd0;
        if (notice_reg) begin
            notice_next = 1'b0;
            sel_kind    = work_reg.active ? KIND_ACTIVE : KIND_CENTERED;
            sel_code    = work_reg.active ? work_reg.dir : 4'd0;
        end else if (work_reg.rel_one) begin
            work_next.rel_one = 1'b0;
            sel_kind          = KIND_RELEASE;
            sel_code          = work_reg.rel_code;
        end else if (work_reg.rel_bits != 4'd0) begin
            bit_sel            = first_bit(work_reg.rel_bits);
            work_next.rel_bits = work_reg.rel_bits & ~bit_sel;
            sel_kind           = KIND_RELEASE;
            sel_code           = bit_sel;
        end else if (work_reg.prs_one) begin
            work_next.prs_one = 1'b0;
            sel_kind          = KIND_PRESS;
            sel_code          = work_reg.prs_code;
        end else begin
            bit_sel            = first_bit(work_reg.prs_bits);
            work_next.prs_bits = work_reg.prs_bits & ~bit_sel;
            sel_kind           = KIND_PRESS;
            sel_code           = bit_sel;
        end
        sel_last = !(work_next.rel_one || (work_next.rel_bits != 4'd0)
                     || work_next.prs_one || (work_next.prs_bits != 4'd0));
    end

    assign pop = !q_empty && (!pending || (emit && sel_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notice_reg  <= 1'b0;
            work_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                work_reg   <= q_data;
                notice_reg <= 1'b1;
            end else if (emit) begin
                work_reg   <= work_next;
                notice_reg <= notice_next;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= sel_kind;
            code_reg <= sel_code;
            flag_reg <= work_reg.flag;
            last_reg <= sel_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_button_code     = code_reg;
    assign m_ignore_sets_out = flag_reg;
    assign m_last            = last_reg;

endmodule

`default_nettype wire

FILE: sv/dpad_direction_to_button_events_top.sv
// Hat-switch direction to button event converter: each change of a 4-bit hat
// direction yields one active or centered notice word, then button release words and
// then button press words, as the 2-bit pad mode register selects (standard, eight-way,
// four-way cardinal, four-way diagonal); the last word of a change carries m_last. An
// input word whose direction equals the previous one yields nothing. The front end takes
// one input word per cycle as long as its command queue (QUEUE_DEPTH entries) has room;
// the sequencer sends one result word per cycle while m_ready does not stall it, so the
// result port sets the sustained rate. Write the mode through cfg_data only while no
// results are outstanding. Depends on dpad_pkg, dpad_front, dpad_queue and dpad_back.
`default_nettype none

module dpad_direction_to_button_events_top #(
    parameter int QUEUE_DEPTH = dpad_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_direction,
    input  wire logic        s_ignore_sets,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [3:0]       m_button_code,
    output logic             m_ignore_sets_out,
    output logic             m_last
);
    import dpad_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    dpad_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_direction   (s_direction),
        .s_ignore_sets (s_ignore_sets),
        .q_full        (q_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    dpad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (pop_cmd)
    );

    dpad_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_empty           (q_empty),
        .q_data            (pop_cmd),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_button_code     (m_button_code),
        .m_ignore_sets_out (m_ignore_sets_out),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire

FILE: sv/dpad_checker.sv
// Port-level checker for the hat-switch event converter, bound to the top level.
// Depends on dpad_pkg and dpad_direction_to_button_events_top.
`default_nettype none

module dpad_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_event_kind,
    input wire logic [3:0] m_button_code,
    input wire logic       m_ignore_sets_out,
    input wire logic       m_last
);
    import dpad_pkg::*;

    logic expect_notice_reg;

    // The first word of every change of direction must be a notice.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_notice_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            expect_notice_reg <= m_last;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind)
            && $stable(m_button_code) && $stable(m_ignore_sets_out) && $stable(m_last))
        else $error("Result word changed while stalled.");

    a_notice_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && expect_notice_reg |->
            m_event_kind == KIND_ACTIVE || m_event_kind == KIND_CENTERED)
        else $error("Change of direction did not start with a notice.");

    a_notice_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !expect_notice_reg |->
            m_event_kind == KIND_RELEASE || m_event_kind == KIND_PRESS)
        else $error("Notice inside a change of direction.");

    a_button_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_RELEASE || m_event_kind == KIND_PRESS)
            |-> m_button_code != 4'd0)
        else $error("Button event without a button.");

    a_centered_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_CENTERED |-> m_button_code == 4'd0)
        else $error("Centered notice with a nonzero code.");

endmodule

bind dpad_direction_to_button_events_top dpad_checker u_dpad_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_event_kind      (m_event_kind),
    .m_button_code     (m_button_code),
    .m_ignore_sets_out (m_ignore_sets_out),
    .m_last            (m_last)
);

`default_nettype wire
